// File: rtl/core/qsr_pkg.sv
`default_nettype none
package qsr_pkg;

  localparam int INSTRUMENTS = 6;
  localparam int STEPS       = 64;
  localparam int MAX_QUANT   = 16;

  localparam int SUBSTEPS    = 4;
  localparam int OP_W        = 2;
  localparam int INST_W      = 3;
  localparam int STEP_W      = 6;
  localparam int SUB_W       = 2;
  localparam int POS_W       = 8;
  localparam int WORD_W      = 9;
  localparam int QUANT_W     = 5;
  localparam int GATE_W      = 6;
  localparam int CODE_W      = 2;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;

  localparam int DEPTH       = INSTRUMENTS * STEPS;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int DIV_W       = POS_W + 2;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int STEP_WRAPS  = (1 << STEP_W) / STEPS;

  localparam logic [WORD_W-1:0] MUTED_WORD  = WORD_W'(9'h100);
  localparam int                MUTE_BIT    = WORD_W - 1;
  localparam logic [CODE_W-1:0] CODE_NORMAL = 2'd1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_NOTE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE  = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [INST_W-1:0] instrument;
    logic [STEP_W-1:0] play_step;
    logic [SUB_W-1:0]  play_substep;
    logic              closer_next;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [INST_W-1:0] instrument_out;
    logic [STEP_W-1:0] step_index;
    logic [WORD_W-1:0] step_word;
    logic [POS_W-1:0]  position;
    logic              last;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/core/qsr_ram.sv
`default_nettype none
module qsr_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/quantized_step_recorder_top.sv
// Flow: an accepted start or tick goes through the divider iterations, one multiply and one
// decide, then the step updates of its run and its notes; a stop skips all three. A run is 1
// substep for trigger instruments and quant_size for gate ones; each step update is a
// read and a write on the single pattern RAM port. Items are taken one at a time.
// Reset: synchronous, active low; afterwards a clearing pass mutes all 384 pattern entries
// while in_stall stays high. Configuration writes are taken at any time.
`default_nettype none
module quantized_step_recorder_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire qsr_pkg::in_item_t            in_data,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      qsr_pkg::out_item_t           out_data,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [qsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qsr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qsr_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_QPOS   = 8'b0000_1000,
    S_DECIDE = 8'b0001_0000,
    S_RD     = 8'b0010_0000,
    S_WR     = 8'b0100_0000,
    S_NOTE   = 8'b1000_0000
  } state_t;

  function automatic logic [STEP_W-1:0] wrap_step(input logic [STEP_W-1:0] s);
    logic [STEP_W:0] v;
    v = {1'b0, s};
    for (int i = 0; i < STEP_WRAPS; i++) begin
      if (v >= (STEP_W + 1)'(STEPS)) v = v - (STEP_W + 1)'(STEPS);
    end
    return v[STEP_W-1:0];
  endfunction

  state_t                 state_r, state_nxt;
  logic [ADDR_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic [QUANT_W-1:0]     quant_r, quant_nxt;
  logic [GATE_W-1:0]      gmask_r, gmask_nxt;
  logic                   rec_r [INSTRUMENTS];
  logic                   rec_nxt [INSTRUMENTS];
  logic [POS_W-1:0]       lp_r [INSTRUMENTS];
  logic [POS_W-1:0]       lp_nxt [INSTRUMENTS];
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  logic [OP_W-1:0]        op_r, op_nxt;
  logic [INST_W-1:0]      inst_r, inst_nxt;
  logic                   gate_r, gate_nxt;
  logic [QUANT_W-1:0]     q_r, q_nxt;
  logic [DIV_W-1:0]       dq_r, dq_nxt;
  logic [QUANT_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [POS_W-1:0]       run_start_r, run_start_nxt;
  logic [POS_W-1:0]       run_pos_r, run_pos_nxt;
  logic [QUANT_W-1:0]     run_cnt_r, run_cnt_nxt;
  logic [1:0]             notes_r, notes_nxt;

  logic [QUANT_W-1:0]     grid_q;
  logic                   slot_free;
  logic [STEP_W-1:0]      run_step;
  logic [ADDR_W-1:0]      run_addr;
  logic [QUANT_W:0]       trial;
  logic [QUANT_W:0]       divisor;
  logic                   trial_ge;
  logic [WORD_W-1:0]      new_word;
  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_addr;
  logic [WORD_W-1:0]      ram_wdata, ram_rdata;

  assign grid_q = (quant_r == '0) ? QUANT_W'(1) :
                  (quant_r > QUANT_W'(MAX_QUANT)) ? QUANT_W'(MAX_QUANT) : quant_r;
  assign slot_free = !out_valid_r || !out_stall;
  assign run_step  = wrap_step(run_pos_r[POS_W-1:SUB_W]);
  assign run_addr  = ADDR_W'(ADDR_W'(inst_r) * ADDR_W'(STEPS)) + ADDR_W'(run_step);
  assign divisor   = {q_r, 1'b0};
  assign trial     = {rem_r, dq_r[DIV_W-1]};
  assign trial_ge  = trial >= divisor;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    new_word = ram_rdata[MUTE_BIT] ? '0 : ram_rdata;
    for (int i = 0; i < SUBSTEPS; i++) begin
      if (run_pos_r[SUB_W-1:0] == SUB_W'(i)) new_word[CODE_W*i +: CODE_W] = CODE_NORMAL;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    quant_nxt     = quant_r;
    gmask_nxt     = gmask_r;
    rec_nxt       = rec_r;
    lp_nxt        = lp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    op_nxt        = op_r;
    inst_nxt      = inst_r;
    gate_nxt      = gate_r;
    q_nxt         = q_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    pos_nxt       = pos_r;
    run_start_nxt = run_start_r;
    run_pos_nxt   = run_pos_r;
    run_cnt_nxt   = run_cnt_r;
    notes_nxt     = notes_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = run_addr;
    ram_wdata     = new_word;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_QUANT: quant_nxt = cfg_data[QUANT_W-1:0];
        CFG_GATE:  gmask_nxt = cfg_data[GATE_W-1:0];
        default:   ;
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr_r;
        ram_wdata = MUTED_WORD;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) state_nxt = S_IDLE;
        else clr_addr_nxt = clr_addr_r + 1'b1;
      end
      S_IDLE: begin
        if (in_valid && int'(in_data.instrument) < INSTRUMENTS) begin
          op_nxt      = in_data.opcode;
          inst_nxt    = in_data.instrument;
          gate_nxt    = gmask_r[in_data.instrument];
          q_nxt       = grid_q;
          dq_nxt      = DIV_W'({in_data.play_step, in_data.play_substep, 1'b0}) +
                        (in_data.closer_next ? DIV_W'(grid_q) : '0);
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          if (in_data.opcode == OP_START) begin
            state_nxt = S_DIV;
          end else if (in_data.opcode == OP_TICK) begin
            if (gmask_r[in_data.instrument] && rec_r[in_data.instrument]) state_nxt = S_DIV;
          end else if (in_data.opcode == OP_STOP) begin
            if (rec_r[in_data.instrument]) begin
              rec_nxt[in_data.instrument] = 1'b0;
              run_start_nxt = lp_r[in_data.instrument];
              run_pos_nxt   = lp_r[in_data.instrument];
              run_cnt_nxt   = gmask_r[in_data.instrument] ? grid_q : QUANT_W'(1);
              notes_nxt     = 2'd1;
              state_nxt     = S_RD;
            end
          end
        end
      end
      S_DIV: begin
        rem_nxt     = trial_ge ? QUANT_W'(trial - divisor) : trial[QUANT_W-1:0];
        dq_nxt      = {dq_r[DIV_W-2:0], trial_ge};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_W - 1)) state_nxt = S_QPOS;
      end
      S_QPOS: begin
        pos_nxt   = POS_W'(dq_r * q_r);
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        notes_nxt = 2'd1;
        if (op_r == OP_START) begin
          lp_nxt[inst_r]  = pos_r;
          rec_nxt[inst_r] = gate_r;
          run_start_nxt   = pos_r;
          run_pos_nxt     = pos_r;
          run_cnt_nxt     = gate_r ? q_r : QUANT_W'(1);
          notes_nxt       = gate_r ? 2'd1 : 2'd2;
          state_nxt       = S_RD;
        end else if (pos_r != lp_r[inst_r]) begin
          run_start_nxt  = lp_r[inst_r];
          run_pos_nxt    = lp_r[inst_r];
          run_cnt_nxt    = q_r;
          lp_nxt[inst_r] = pos_r;
          state_nxt      = S_RD;
        end else begin
          state_nxt = S_NOTE;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (slot_free) begin
          ram_we                 = 1'b1;
          out_valid_nxt          = 1'b1;
          out_nxt.kind           = KIND_WRITE;
          out_nxt.instrument_out = inst_r;
          out_nxt.step_index     = run_step;
          out_nxt.step_word      = new_word;
          out_nxt.position       = run_start_r;
          out_nxt.last           = 1'b0;
          if (run_cnt_r == QUANT_W'(1)) begin
            state_nxt = S_NOTE;
          end else begin
            run_cnt_nxt = run_cnt_r - 1'b1;
            run_pos_nxt = run_pos_r + 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      S_NOTE: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.kind           = KIND_NOTE;
          out_nxt.instrument_out = inst_r;
          out_nxt.step_index     = '0;
          out_nxt.step_word      = '0;
          out_nxt.position       = lp_r[inst_r];
          out_nxt.last           = (notes_r == 2'd1);
          notes_nxt              = notes_r - 1'b1;
          if (notes_r == 2'd1) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      quant_r     <= QUANT_W'(1);
      gmask_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < INSTRUMENTS; i++) begin
        rec_r[i] <= 1'b0;
        lp_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      quant_r     <= quant_nxt;
      gmask_r     <= gmask_nxt;
      out_valid_r <= out_valid_nxt;
      rec_r       <= rec_nxt;
      lp_r        <= lp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r       <= out_nxt;
    op_r        <= op_nxt;
    inst_r      <= inst_nxt;
    gate_r      <= gate_nxt;
    q_r         <= q_nxt;
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
    pos_r       <= pos_nxt;
    run_start_r <= run_start_nxt;
    run_pos_r   <= run_pos_nxt;
    run_cnt_r   <= run_cnt_nxt;
    notes_r     <= notes_nxt;
  end

  qsr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_pattern (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// File: rtl/core/qsr_checker.sv
`default_nettype none
module qsr_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire qsr_pkg::in_item_t              in_data,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire qsr_pkg::out_item_t             out_data,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [qsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [qsr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qsr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result transaction offered right after reset");

  a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_WRITE |-> !out_data.last && !out_data.step_word[MUTE_BIT])
    else $error("step write marked last or left muted");

  a_note_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_NOTE |-> out_data.step_index == '0 &&
      out_data.step_word == '0)
    else $error("note transaction carries step data");

endmodule

bind quantized_step_recorder_top qsr_checker u_qsr_checker (.*);
`default_nettype wire

// File: bench/quantized_step_recorder_top_test.sv
module quantized_step_recorder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qsr_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 50;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  quantized_step_recorder_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // recorder state as seen by the bench
  logic [WORD_W-1:0] pattern_mem [DEPTH];
  logic rec_on [INSTRUMENTS];
  logic [POS_W-1:0] last_pos [INSTRUMENTS];
  logic [QUANT_W-1:0] quant_reg;
  logic [GATE_W-1:0] gate_reg;

  in_item_t hit_queue [$];
  out_item_t due_results [$];
  out_item_t event_results [$];

  logic in_busy;
  logic in_taken;
  logic out_taken;
  logic hold_req;
  logic burst_mode;
  int unsigned in_wait;
  int unsigned out_wait;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned mismatches;

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned pause_len();
    if (burst_mode) return 0;
    return $urandom_range(0, 4);
  endfunction

  function automatic int unsigned grid_size();
    int unsigned q;
    q = quant_reg;
    if (q < 1) q = 1;
    if (q > MAX_QUANT) q = MAX_QUANT;
    return q;
  endfunction

  function automatic logic [POS_W-1:0] snap_position(in_item_t it);
    int unsigned q;
    int unsigned d;
    q = grid_size();
    d = (it.play_step * SUBSTEPS + it.play_substep) * 2 + (it.closer_next ? q : 0);
    return POS_W'((d / (2 * q)) * q);
  endfunction

  function automatic void note_result(int unsigned inst);
    out_item_t r;
    r = '0;
    r.kind = KIND_NOTE;
    r.instrument_out = INST_W'(inst);
    r.position = last_pos[inst];
    event_results.push_back(r);
  endfunction

  function automatic void run_result(int unsigned inst, logic [POS_W-1:0] start);
    int unsigned len;
    int unsigned st;
    int unsigned sh;
    logic [POS_W-1:0] p;
    logic [WORD_W-1:0] w;
    out_item_t r;
    len = gate_reg[inst] ? grid_size() : 1;
    for (int unsigned i = 0; i < len; i++) begin
      p = start + POS_W'(i);
      st = (p / SUBSTEPS) % STEPS;
      sh = (p % SUBSTEPS) * CODE_W;
      w = pattern_mem[inst * STEPS + st];
      if (w[MUTE_BIT]) w = '0;
      w = (w & ~(WORD_W'(3) << sh)) | (WORD_W'(CODE_NORMAL) << sh);
      pattern_mem[inst * STEPS + st] = w;
      r = '0;
      r.kind = KIND_WRITE;
      r.instrument_out = INST_W'(inst);
      r.step_index = STEP_W'(st);
      r.step_word = w;
      r.position = start;
      event_results.push_back(r);
    end
  endfunction

  function automatic void close_recording(int unsigned inst);
    if (rec_on[inst]) begin
      rec_on[inst] = 1'b0;
      run_result(inst, last_pos[inst]);
      note_result(inst);
    end
  endfunction

  function automatic void predict_recording(in_item_t it);
    int unsigned inst;
    logic [POS_W-1:0] cur;
    event_results.delete();
    inst = it.instrument;
    if (inst < INSTRUMENTS) begin
      case (it.opcode)
        OP_START: begin
          rec_on[inst] = 1'b1;
          last_pos[inst] = snap_position(it);
          if (!gate_reg[inst]) close_recording(inst);
          else run_result(inst, last_pos[inst]);
          note_result(inst);
        end
        OP_STOP: close_recording(inst);
        OP_TICK: begin
          if (gate_reg[inst] && rec_on[inst]) begin
            cur = snap_position(it);
            if (cur != last_pos[inst]) begin
              run_result(inst, last_pos[inst]);
              last_pos[inst] = cur;
            end
            note_result(inst);
          end
        end
        default: ;
      endcase
    end
    if (event_results.size() > 0) event_results[event_results.size() - 1].last = 1'b1;
    foreach (event_results[i]) due_results.push_back(event_results[i]);
  endfunction

  function automatic in_item_t hit_item(logic [OP_W-1:0] op, int unsigned inst,
                                        int unsigned p, logic closer);
    in_item_t it;
    it.opcode = op;
    it.instrument = INST_W'(inst);
    it.play_step = STEP_W'(p / SUBSTEPS);
    it.play_substep = SUB_W'(p % SUBSTEPS);
    it.closer_next = closer;
    return it;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_QUANT) quant_reg = val[QUANT_W-1:0];
    else gate_reg = val[GATE_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_quiet();
    do @(posedge clk); while (hit_queue.size() != 0 || in_busy || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned made;
    int unsigned inst;
    int unsigned p;
    int unsigned ticks;
    logic [$bits(in_item_t)-1:0] raw;
    in_item_t it;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) < 2) begin
        raw = $urandom_range(0, (1 << $bits(in_item_t)) - 1);
        it = in_item_t'(raw);
        hit_queue.push_back(it);
        if (it.opcode != OP_NONE && it.instrument < INSTRUMENTS) made++;
      end else begin
        inst = $urandom_range(0, INSTRUMENTS - 1);
        p = $urandom_range(0, 255);
        hit_queue.push_back(hit_item(OP_START, inst, p, 1'($urandom)));
        ticks = $urandom_range(0, 6);
        repeat (ticks) begin
          p = (p + $urandom_range(0, 8)) % 256;
          hit_queue.push_back(hit_item(OP_TICK, inst, p, 1'($urandom)));
        end
        if ($urandom_range(0, 4) != 0)
          hit_queue.push_back(hit_item(OP_STOP, inst, p, 1'($urandom)));
        made += ticks + 2;
      end
    end
  endtask

  // driver: one transaction at a time, random gap after each outside burst mode
  always @(negedge clk) begin : driver
    if (in_taken) begin
      in_taken = 1'b0;
      in_busy = 1'b0;
      in_wait = pause_len();
    end
    if (!in_busy && rst_n) begin
      if (in_wait > 0) begin
        in_wait--;
      end else if (hit_queue.size() > 0) begin
        in_data <= hit_queue.pop_front();
        in_busy = 1'b1;
      end
    end
    in_valid <= in_busy;
  end

  always @(posedge clk) begin : accept_in
    if (rst_n && in_valid && !in_stall) begin
      predict_recording(in_data);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : receiver
    if (out_taken) begin
      out_taken = 1'b0;
      out_wait = pause_len();
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (out_wait > 0) begin
      out_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      out_taken = 1'b1;
      if (due_results.size() == 0) begin
        $error("unexpected result %p", out_data);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_data.kind);
          mismatches++;
        end
        if (out_data.instrument_out !== want.instrument_out) begin
          $error("instrument_out: expected %0d, actual %0d",
                 want.instrument_out, out_data.instrument_out);
          mismatches++;
        end
        if (out_data.step_index !== want.step_index) begin
          $error("step_index: expected %0d, actual %0d", want.step_index, out_data.step_index);
          mismatches++;
        end
        if (out_data.step_word !== want.step_word) begin
          $error("step_word: expected %h, actual %h", want.step_word, out_data.step_word);
          mismatches++;
        end
        if (out_data.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_data.position);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_data.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_busy = 1'b0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    hold_req = 1'b0;
    burst_mode = 1'b0;
    in_wait = 0;
    out_wait = 0;
    hold_left = 0;
    cycle_count = 0;
    mismatches = 0;
    quant_reg = 5'd1;
    gate_reg = '0;
    for (int i = 0; i < DEPTH; i++) pattern_mem[i] = MUTED_WORD;
    for (int i = 0; i < INSTRUMENTS; i++) begin
      rec_on[i] = 1'b0;
      last_pos[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // grid of zero, odd instruments gated
    write_reg(CFG_QUANT, 6'd0);
    write_reg(CFG_GATE, 6'b101010);
    hit_queue.push_back(hit_item(OP_START, 0, 0, 1'b0));
    hit_queue.push_back(hit_item(OP_START, 0, 255, 1'b1));
    hit_queue.push_back(hit_item(OP_START, 1, 42, 1'b0));
    hit_queue.push_back(hit_item(OP_TICK, 1, 42, 1'b0));
    hit_queue.push_back(hit_item(OP_TICK, 1, 45, 1'b1));
    hit_queue.push_back(hit_item(OP_STOP, 1, 46, 1'b0));
    hit_queue.push_back(hit_item(OP_STOP, 1, 46, 1'b0));
    hit_queue.push_back(hit_item(OP_TICK, 0, 10, 1'b0));
    hit_queue.push_back(hit_item(OP_TICK, 3, 10, 1'b0));
    hit_queue.push_back(hit_item(OP_NONE, 2, 20, 1'b1));
    hit_queue.push_back(hit_item(OP_START, 6, 20, 1'b0));
    hit_queue.push_back(hit_item(OP_START, 7, 255, 1'b1));
    wait_for_quiet();

    // run that wraps past position 255
    write_reg(CFG_QUANT, 6'd13);
    write_reg(CFG_GATE, 6'b111111);
    hit_queue.push_back(hit_item(OP_START, 5, 247, 1'b0));
    hit_queue.push_back(hit_item(OP_TICK, 5, 255, 1'b1));
    hit_queue.push_back(hit_item(OP_STOP, 5, 255, 1'b1));
    hit_queue.push_back(hit_item(OP_START, 2, 0, 1'b1));
    hit_queue.push_back(hit_item(OP_STOP, 2, 3, 1'b0));
    wait_for_quiet();

    // grid above the maximum
    write_reg(CFG_QUANT, 6'b110001);
    hit_queue.push_back(hit_item(OP_START, 4, 255, 1'b1));
    hit_queue.push_back(hit_item(OP_TICK, 4, 16, 1'b0));
    hit_queue.push_back(hit_item(OP_TICK, 4, 16, 1'b0));
    hit_queue.push_back(hit_item(OP_STOP, 4, 17, 1'b0));
    hit_queue.push_back(hit_item(OP_START, 3, 129, 1'b0));
    hit_queue.push_back(hit_item(OP_STOP, 3, 130, 1'b0));
    wait_for_quiet();

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_QUANT, 6'd16);
          write_reg(CFG_GATE, 6'b111111);
        end
        1: begin
          write_reg(CFG_QUANT, 6'd1);
          write_reg(CFG_GATE, 6'b000000);
        end
        default: begin
          write_reg(CFG_QUANT, CFG_DATA_W'($urandom_range(0, 63)));
          write_reg(CFG_GATE, CFG_DATA_W'($urandom_range(0, 63)));
        end
      endcase
      burst_mode = (phase == 3 || phase == 6);
      if (phase == 4) hold_req = 1'b1;
      queue_random(ITEMS_PER_PHASE);
      wait_for_quiet();
    end
    burst_mode = 1'b0;

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: quantized_step_recorder_top.f
rtl/core/qsr_pkg.sv
rtl/core/qsr_ram.sv
rtl/core/quantized_step_recorder_top.sv
rtl/core/qsr_checker.sv
bench/quantized_step_recorder_top_test.sv
